[rtl/binary_clock_tick_counter_defines.svh]
// Assertion macros for the binary clock tick counter.
// The host module must provide clk and rst.
`ifndef BINARY_CLOCK_TICK_COUNTER_DEFINES_SVH
`define BINARY_CLOCK_TICK_COUNTER_DEFINES_SVH

`ifndef SYNTH
`define BCTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCTC_ASSERT(label, prop, msg)
`define BCTC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/bctc_pkg.sv]
package bctc_pkg;

  localparam int STEP_W   = 23;
  localparam int ACC_W    = 24;
  localparam int PRESS_W  = 8;
  localparam int HOUR_W   = 4;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int LED_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd2;

  localparam logic [STEP_W-1:0]  TICK_STEP_RST     = 23'd32768;
  localparam logic [ACC_W-1:0]   SECOND_PERIOD_RST = 24'd1000000;
  localparam logic [PRESS_W-1:0] LONG_PRESS_RST    = 8'd15;

  localparam logic [ACC_W-1:0]   ACC_MAX    = '1;
  localparam logic [PRESS_W-1:0] PRESS_MAX  = '1;
  localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_LAST  = 4'd11;

  typedef struct packed {
    logic [STEP_W-1:0]  tick_step;
    logic [ACC_W-1:0]   second_period;
    logic [PRESS_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [LED_W-1:0]  port_a;
    logic [LED_W-1:0]  port_b;
    logic              updated;
  } result_t;

  // Active-low hour byte: h3 -> bit1, h2 -> bit0, h1 -> bit7, h0 -> bit6.
  function automatic logic [LED_W-1:0] hour_leds(input logic [HOUR_W-1:0] h);
    logic [LED_W-1:0] a;
    a    = '0;
    a[1] = h[3];
    a[0] = h[2];
    a[7] = h[1];
    a[6] = h[0];
    return ~a;
  endfunction

  // Active-low minute byte: m5 -> bit2, m4..m0 -> bits 7..3.
  function automatic logic [LED_W-1:0] minute_leds(input logic [MIN_W-1:0] m);
    logic [LED_W-1:0] b;
    b      = '0;
    b[2]   = m[5];
    b[7:3] = m[4:0];
    return ~b;
  endfunction

endpackage

[rtl/bctc_cfg.sv]
module bctc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bctc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bctc_pkg::cfg_t                 cfg
);
  import bctc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_step        <= TICK_STEP_RST;
      cfg.second_period    <= SECOND_PERIOD_RST;
      cfg.long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_STEP:     cfg.tick_step        <= cfg_data[STEP_W-1:0];
        CFG_SECOND_PERIOD: cfg.second_period    <= cfg_data[ACC_W-1:0];
        CFG_LONG_PRESS:    cfg.long_press_ticks <= cfg_data[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/bctc_core.sv]
`include "binary_clock_tick_counter_defines.svh"

module bctc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              button,
  input  bctc_pkg::cfg_t    cfg,
  output bctc_pkg::result_t res
);
  import bctc_pkg::*;

  logic [ACC_W-1:0]   micro_accumulator, micro_accumulator_next;
  logic [SEC_W-1:0]   second_count, second_count_next;
  logic [MIN_W-1:0]   minute_count, minute_count_next;
  logic [HOUR_W-1:0]  hour_count, hour_count_next;
  logic [PRESS_W-1:0] press_length, press_length_next;
  logic               was_pressed;
  logic [LED_W-1:0]   port_a_latch, port_a_latch_next;
  logic [LED_W-1:0]   port_b_latch, port_b_latch_next;

  logic               pressed, release_evt, short_press;
  logic [PRESS_W-1:0] press_inc;
  logic [MIN_W-1:0]   min_btn;
  logic [HOUR_W-1:0]  hour_btn;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic               sec_adv, sec_wrap, min_wrap, updated;

  always_comb begin
    pressed     = ~button;
    press_inc   = (pressed && press_length != PRESS_MAX) ? press_length + 1'b1 : press_length;
    release_evt = was_pressed && !pressed;
    short_press = press_inc < cfg.long_press_ticks;

    // Button adjust: minute or hour, each wrapping on its own without carry.
    min_btn  = minute_count;
    hour_btn = hour_count;
    if (release_evt && short_press) begin
      min_btn = (minute_count == MIN_LAST) ? '0 : minute_count + 1'b1;
    end
    if (release_evt && !short_press) begin
      hour_btn = (hour_count == HOUR_LAST) ? '0 : hour_count + 1'b1;
    end
    press_length_next = release_evt ? '0 : press_inc;

    acc_sum = {1'b0, micro_accumulator} + {2'b00, cfg.tick_step};
    acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    sec_adv = acc_sat >= cfg.second_period;
    micro_accumulator_next = sec_adv ? acc_sat - cfg.second_period : acc_sat;

    sec_wrap = sec_adv && second_count == SEC_LAST;
    min_wrap = sec_wrap && min_btn == MIN_LAST;
    second_count_next = sec_adv ? (sec_wrap ? '0 : second_count + 1'b1) : second_count;
    minute_count_next = sec_wrap ? (min_wrap ? '0 : min_btn + 1'b1) : min_btn;
    hour_count_next   = min_wrap ? ((hour_btn == HOUR_LAST) ? '0 : hour_btn + 1'b1)
                                 : hour_btn;

    updated           = release_evt || sec_adv;
    port_a_latch_next = updated ? hour_leds(hour_count_next) : port_a_latch;
    port_b_latch_next = updated ? minute_leds(minute_count_next) : port_b_latch;

    res.hours   = hour_count_next;
    res.minutes = minute_count_next;
    res.seconds = second_count_next;
    res.port_a  = port_a_latch_next;
    res.port_b  = port_b_latch_next;
    res.updated = updated;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      micro_accumulator <= '0;
      second_count      <= '0;
      minute_count      <= '0;
      hour_count        <= '0;
      press_length      <= '0;
      was_pressed       <= 1'b0;
      port_a_latch      <= '0;
      port_b_latch      <= '0;
    end else if (tick) begin
      micro_accumulator <= micro_accumulator_next;
      second_count      <= second_count_next;
      minute_count      <= minute_count_next;
      hour_count        <= hour_count_next;
      press_length      <= press_length_next;
      was_pressed       <= pressed;
      port_a_latch      <= port_a_latch_next;
      port_b_latch      <= port_b_latch_next;
    end
  end

  `BCTC_ASSERT_ALWAYS(a_time_range, rst || (hour_count <= HOUR_LAST && minute_count <= MIN_LAST && second_count <= SEC_LAST), "time count out of range")
  `BCTC_ASSERT(a_sec_hold, tick && !sec_adv |=> $stable(second_count), "seconds moved without period")
  `BCTC_ASSERT(a_release_clear, tick && release_evt |=> press_length == '0, "press length not cleared")
  `BCTC_ASSERT(a_leds_hold, !(tick && updated) |=> $stable(port_a_latch) && $stable(port_b_latch), "LED latch changed without update")

endmodule

[rtl/binary_clock_tick_counter.sv]
// Channel  Handshake           Payload
// in       in_valid/in_ready   button_level
// out      out_valid/out_ready hours_now, minutes_now, seconds_now,
//                              port_a_leds, port_b_leds, display_updated
// cfg      cfg_we              cfg_index, cfg_data
//
// One tick per clock sustained unless the output stalls; a beat's result reaches the
// outputs via the input register, then the result register fed by clock update logic.
// The tick update (saturating add, period compare, second/minute/hour carry) is
// one pass of logic between the input register and the result register.
// Reset loads the default configuration and clears time, press state and LED latches.
// A stalled output holds its beat and the input stage keeps at most one beat behind it.
module binary_clock_tick_counter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            button_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bctc_pkg::HOUR_W-1:0]     hours_now,
  output logic [bctc_pkg::MIN_W-1:0]      minutes_now,
  output logic [bctc_pkg::SEC_W-1:0]      seconds_now,
  output logic [bctc_pkg::LED_W-1:0]      port_a_leds,
  output logic [bctc_pkg::LED_W-1:0]      port_b_leds,
  output logic                            display_updated,
  input  logic                            cfg_we,
  input  logic [bctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bctc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bctc_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    in_full;
  logic    button_q;
  logic    adv;

  assign adv      = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || adv;

  bctc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bctc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .tick   (adv),
    .button (button_q),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      button_q <= button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hours_now       <= res.hours;
      minutes_now     <= res.minutes;
      seconds_now     <= res.seconds;
      port_a_leds     <= res.port_a;
      port_b_leds     <= res.port_b;
      display_updated <= res.updated;
    end
  end

endmodule
